@@ rtl/label_region_statistics_core_assert.svh @@
// Assertion macros used by the checker file of the region statistics block.
`ifndef LABEL_REGION_STATISTICS_CORE_ASSERT_SVH
`define LABEL_REGION_STATISTICS_CORE_ASSERT_SVH

// Check that is switched off while reset is held.
`define LRS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("label_region_statistics_core: check failed");

// Check that also applies during reset.
`define LRS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("label_region_statistics_core: check failed");

`endif

@@ rtl/lrs_pkg.sv @@
// Shared types and constants of the label region statistics block.
`timescale 1ns / 1ps

package lrs_pkg;

  // Field widths.
  localparam int DIM_W   = 11;
  localparam int AREA_W  = 21;
  localparam int SUM_W   = 30;
  localparam int PERIM_W = 23;
  localparam int CENT_W  = 10;
  localparam int LABEL_W = 10;
  localparam int CFG_W   = 21;
  localparam int CFG_IDX_W = 2;

  // Saturation limits.
  localparam logic [AREA_W-1:0]  AREA_CAP  = {AREA_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_CAP   = {SUM_W{1'b1}};
  localparam logic [PERIM_W-1:0] PERIM_CAP = {PERIM_W{1'b1}};
  localparam logic [CENT_W-1:0]  CENT_CAP  = {CENT_W{1'b1}};

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_MAX     = 2'd3;

  // Register reset values.
  localparam logic [DIM_W-1:0]  DIM_RESET      = 11'd1024;
  localparam logic [AREA_W-1:0] AREA_MIN_RESET = 21'd1;
  localparam logic [AREA_W-1:0] AREA_MAX_RESET = 21'(1024 * 1024);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [AREA_W-1:0] area_min;
    logic [AREA_W-1:0] area_max;
  } cfg_t;

  // One table entry handed to the centroid divider.
  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [PERIM_W-1:0] perimeter;
    logic               in_range;
    logic [LABEL_W-1:0] highest_label;
  } div_req_t;

endpackage

@@ rtl/lrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lrs_front.sv @@
// Front part: accepts transactions, tracks the raster position and classifies pixels.
`timescale 1ns / 1ps

module lrs_front #(
  parameter int MAX_LABELS = 1024,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int IW = $clog2(MAX_LABELS),
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int QW = 1 + IW + 2 + 1 + IW + 1 + IW + XW + YW + lrs_pkg::LABEL_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrs_pkg::cfg_t                cfg,
  input  logic                         hold,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [lrs_pkg::LABEL_W-1:0]  in_label,
  output logic                         push,
  output logic [QW-1:0]                push_data
);

  localparam int WLW = $clog2(MAX_WIDTH + 1);
  localparam int HLW = $clog2(MAX_HEIGHT + 1);
  localparam logic [31:0] ML = 32'(MAX_LABELS);

  logic [XW-1:0] col_r;
  logic [YW-1:0] row_r;
  logic [IW-1:0] left_r;
  logic [lrs_pkg::LABEL_W-1:0] max_r, max_nxt;

  logic                        f1_valid_r;
  logic                        f1_cmd_r;
  logic [IW-1:0]               f1_lab_r;
  logic [IW-1:0]               f1_left_r;
  logic [XW-1:0]               f1_x_r;
  logic [YW-1:0]               f1_y_r;
  logic                        f1_border_r;
  logic [lrs_pkg::LABEL_W-1:0] f1_hl_r;

  logic [WLW-1:0] w_lim;
  logic [HLW-1:0] h_lim;
  logic last_col, last_row, border, accept;
  logic [lrs_pkg::LABEL_W-1:0] lab_rem;
  logic [IW-1:0] lab_mod, up_lab;
  logic up_diff, left_diff;
  logic [1:0] own_inc;

  assign in_stall = f1_valid_r || hold;
  assign accept   = in_valid && !in_stall;

  // Effective image size: zero acts as one, larger values stop at the maximum.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_lim = WLW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_lim = WLW'(MAX_WIDTH);
    end else begin
      w_lim = WLW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_lim = HLW'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h_lim = HLW'(MAX_HEIGHT);
    end else begin
      h_lim = HLW'(cfg.image_height);
    end
  end

  assign last_col = (32'(col_r) + 32'd1) >= 32'(w_lim);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(h_lim);
  assign border   = (col_r == '0) || (row_r == '0) || last_col || last_row;

  // Label reduced modulo the table depth by conditional subtraction.
  always_comb begin
    lab_rem = in_label;
    for (int k = 9; k >= 0; k--) begin
      if ({22'd0, lab_rem} >= (ML << k)) begin
        lab_rem = lab_rem - lrs_pkg::LABEL_W'(ML << k);
      end
    end
  end
  assign lab_mod = IW'(lab_rem);
  assign max_nxt = (lrs_pkg::LABEL_W'(lab_mod) > max_r) ? lrs_pkg::LABEL_W'(lab_mod) : max_r;

  // Raster position, left neighbor and highest label.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      max_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
      if (accept && !in_cmd) begin
        left_r <= lab_mod;
        max_r  <= max_nxt;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + YW'(1);
        end else begin
          col_r <= col_r + XW'(1);
        end
      end
    end
  end

  // Classification stage register.
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_cmd_r    <= in_cmd;
      f1_lab_r    <= lab_mod;
      f1_left_r   <= left_r;
      f1_x_r      <= col_r;
      f1_y_r      <= row_r;
      f1_border_r <= border;
      f1_hl_r     <= max_r;
    end
  end

  // Labels of the previous row, read at acceptance and written in the next cycle.
  lrs_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (f1_valid_r && !f1_cmd_r),
    .waddr (f1_x_r),
    .wdata (f1_lab_r),
    .raddr (col_r),
    .rdata (up_lab)
  );

  // Neighbor comparisons and own perimeter increment.
  assign up_diff   = (f1_y_r != '0) && (up_lab != f1_lab_r);
  assign left_diff = (f1_x_r != '0) && (f1_left_r != f1_lab_r);
  assign own_inc   = 2'(f1_border_r) + 2'(up_diff) + 2'(left_diff);

  assign push      = f1_valid_r;
  assign push_data = {f1_cmd_r, f1_lab_r, own_inc, up_diff, up_lab, left_diff, f1_left_r,
                      f1_x_r, f1_y_r, f1_hl_r};

endmodule

@@ rtl/lrs_queue.sv @@
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps

module lrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             almost_full
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;

  assign head_valid  = count_r != '0;
  assign head_data   = slots_r[rd_ptr_r];
  assign almost_full = 32'(count_r) >= (DEPTH - 1);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/lrs_back.sv @@
// Back part: runs the table read-modify-write operations and the clearing pass.
`timescale 1ns / 1ps

module lrs_back #(
  parameter int MAX_LABELS = 1024,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int IW = $clog2(MAX_LABELS),
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT),
  localparam int QW = 1 + IW + 2 + 1 + IW + 1 + IW + XW + YW + lrs_pkg::LABEL_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lrs_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  logic [QW-1:0]     head_data,
  output logic              pop,
  input  logic              div_busy,
  output logic              div_start,
  output lrs_pkg::div_req_t div_req,
  output logic              clearing
);

  localparam int AW = lrs_pkg::AREA_W;
  localparam int SW = lrs_pkg::SUM_W;
  localparam int PW = lrs_pkg::PERIM_W;

  // Operation kinds.
  localparam logic [1:0] OP_OWN   = 2'd0;
  localparam logic [1:0] OP_PERIM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Phases of one pixel.
  localparam logic [1:0] PH_OWN  = 2'd0;
  localparam logic [1:0] PH_UP   = 2'd1;
  localparam logic [1:0] PH_LEFT = 2'd2;

  logic                        h_cmd, h_up_diff, h_left_diff;
  logic [IW-1:0]               h_lab, h_up_lab, h_left_lab;
  logic [1:0]                  h_own_inc;
  logic [XW-1:0]               h_x;
  logic [YW-1:0]               h_y;
  logic [lrs_pkg::LABEL_W-1:0] h_hl;
  logic                        merged, read_ok;

  logic [1:0]    phase_r, phase_nxt;
  logic          iss_valid;
  logic [1:0]    iss_kind, iss_inc;
  logic [IW-1:0] iss_addr;

  logic                        s1_valid_r;
  logic [1:0]                  s1_kind_r, s1_inc_r;
  logic [IW-1:0]               s1_addr_r;
  logic [XW-1:0]               s1_x_r;
  logic [YW-1:0]               s1_y_r;
  logic [lrs_pkg::LABEL_W-1:0] s1_hl_r;

  logic          clear_r;
  logic [IW-1:0] clr_cnt_r;

  logic          fwd_as_r, fwd_pm_r;
  logic [AW-1:0] fa_area_r;
  logic [SW-1:0] fa_sx_r, fa_sy_r;
  logic [PW-1:0] fp_r;

  logic [AW-1:0] area_rd, cur_area, new_area;
  logic [SW-1:0] sx_rd, sy_rd, cur_sx, cur_sy, new_sx, new_sy;
  logic [PW-1:0] pm_rd, cur_pm, new_pm;
  logic [AW:0]   area_sum;
  logic [SW:0]   sx_sum, sy_sum;
  logic [PW:0]   pm_sum;
  logic          as_we, pm_we, is_read;
  logic [IW-1:0] waddr;

  assign {h_cmd, h_lab, h_own_inc, h_up_diff, h_up_lab, h_left_diff, h_left_lab,
          h_x, h_y, h_hl} = head_data;

  assign merged   = h_up_diff && h_left_diff && (h_up_lab == h_left_lab);
  assign read_ok  = !div_busy && !(s1_valid_r && (s1_kind_r == OP_READ));
  assign clearing = clear_r;

  // Issue a table op a cycle off the queue head unless clearing or a read waits.
  always_comb begin
    iss_valid = 1'b0;
    iss_kind  = OP_OWN;
    iss_addr  = h_lab;
    iss_inc   = h_own_inc;
    pop       = 1'b0;
    phase_nxt = phase_r;
    if (head_valid && !clear_r) begin
      case (phase_r)
        PH_OWN: begin
          if (h_cmd) begin
            if (read_ok) begin
              iss_valid = 1'b1;
              iss_kind  = OP_READ;
              pop       = 1'b1;
            end
          end else begin
            iss_valid = 1'b1;
            if (h_up_diff) begin
              phase_nxt = PH_UP;
            end else if (h_left_diff) begin
              phase_nxt = PH_LEFT;
            end else begin
              pop = 1'b1;
            end
          end
        end
        PH_UP: begin
          iss_valid = 1'b1;
          iss_kind  = OP_PERIM;
          iss_addr  = h_up_lab;
          iss_inc   = merged ? 2'd2 : 2'd1;
          if (h_left_diff && !merged) begin
            phase_nxt = PH_LEFT;
          end else begin
            pop       = 1'b1;
            phase_nxt = PH_OWN;
          end
        end
        PH_LEFT: begin
          iss_valid = 1'b1;
          iss_kind  = OP_PERIM;
          iss_addr  = h_left_lab;
          iss_inc   = 2'd1;
          pop       = 1'b1;
          phase_nxt = PH_OWN;
        end
        default: begin
          phase_nxt = PH_OWN;
        end
      endcase
    end
  end

  // Execute stage: read data with forwarding from the write of the previous cycle.
  assign is_read  = s1_kind_r == OP_READ;
  assign as_we    = s1_valid_r && ((s1_kind_r == OP_OWN) || is_read);
  assign pm_we    = s1_valid_r;
  assign cur_area = fwd_as_r ? fa_area_r : area_rd;
  assign cur_sx   = fwd_as_r ? fa_sx_r : sx_rd;
  assign cur_sy   = fwd_as_r ? fa_sy_r : sy_rd;
  assign cur_pm   = fwd_pm_r ? fp_r : pm_rd;

  // Saturating updates, or zero for a read.
  always_comb begin
    area_sum = {1'b0, cur_area} + (AW+1)'(1);
    sx_sum   = {1'b0, cur_sx} + (SW+1)'(s1_x_r);
    sy_sum   = {1'b0, cur_sy} + (SW+1)'(s1_y_r);
    pm_sum   = {1'b0, cur_pm} + (PW+1)'(s1_inc_r);
    new_area = area_sum[AW] ? lrs_pkg::AREA_CAP : area_sum[AW-1:0];
    new_sx   = sx_sum[SW] ? lrs_pkg::SUM_CAP : sx_sum[SW-1:0];
    new_sy   = sy_sum[SW] ? lrs_pkg::SUM_CAP : sy_sum[SW-1:0];
    new_pm   = pm_sum[PW] ? lrs_pkg::PERIM_CAP : pm_sum[PW-1:0];
    if (is_read) begin
      new_area = '0;
      new_sx   = '0;
      new_sy   = '0;
      new_pm   = '0;
    end
  end

  assign waddr = clear_r ? clr_cnt_r : s1_addr_r;

  // Control registers: phase, execute stage valid, forwarding and clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OWN;
      s1_valid_r <= 1'b0;
      fwd_as_r   <= 1'b0;
      fwd_pm_r   <= 1'b0;
      clear_r    <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      s1_valid_r <= iss_valid;
      fwd_as_r   <= iss_valid && as_we && (s1_addr_r == iss_addr);
      fwd_pm_r   <= iss_valid && pm_we && (s1_addr_r == iss_addr);
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(MAX_LABELS - 1)) begin
          clear_r <= 1'b0;
        end
      end
    end
  end

  // Execute stage payload and forwarded write data.
  always_ff @(posedge clk) begin
    s1_kind_r <= iss_kind;
    s1_addr_r <= iss_addr;
    s1_inc_r  <= iss_inc;
    s1_x_r    <= h_x;
    s1_y_r    <= h_y;
    s1_hl_r   <= h_hl;
    fa_area_r <= new_area;
    fa_sx_r   <= new_sx;
    fa_sy_r   <= new_sy;
    fp_r      <= new_pm;
  end

  // Statistics tables.
  lrs_ram #(.WIDTH (AW), .DEPTH (MAX_LABELS)) u_area_ram (
    .clk (clk), .we (clear_r || as_we), .waddr (waddr),
    .wdata (clear_r ? '0 : new_area), .raddr (iss_addr), .rdata (area_rd)
  );
  lrs_ram #(.WIDTH (SW), .DEPTH (MAX_LABELS)) u_sum_x_ram (
    .clk (clk), .we (clear_r || as_we), .waddr (waddr),
    .wdata (clear_r ? '0 : new_sx), .raddr (iss_addr), .rdata (sx_rd)
  );
  lrs_ram #(.WIDTH (SW), .DEPTH (MAX_LABELS)) u_sum_y_ram (
    .clk (clk), .we (clear_r || as_we), .waddr (waddr),
    .wdata (clear_r ? '0 : new_sy), .raddr (iss_addr), .rdata (sy_rd)
  );
  lrs_ram #(.WIDTH (PW), .DEPTH (MAX_LABELS)) u_perim_ram (
    .clk (clk), .we (clear_r || pm_we), .waddr (waddr),
    .wdata (clear_r ? '0 : new_pm), .raddr (iss_addr), .rdata (pm_rd)
  );

  // Hand a read entry to the divider.
  assign div_start             = s1_valid_r && is_read;
  assign div_req.area          = cur_area;
  assign div_req.sum_x         = cur_sx;
  assign div_req.sum_y         = cur_sy;
  assign div_req.perimeter     = cur_pm;
  assign div_req.in_range      = (cur_area >= cfg.area_min) && (cur_area <= cfg.area_max);
  assign div_req.highest_label = s1_hl_r;

endmodule

@@ rtl/lrs_div.sv @@
// Centroid divider, one quotient bit per cycle, holding the result transaction.
`timescale 1ns / 1ps

module lrs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  lrs_pkg::div_req_t            req,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrs_pkg::AREA_W-1:0]   out_region_area,
  output logic [lrs_pkg::CENT_W-1:0]   out_centroid_x,
  output logic [lrs_pkg::CENT_W-1:0]   out_centroid_y,
  output logic [lrs_pkg::PERIM_W-1:0]  out_perimeter,
  output logic                         out_in_range,
  output logic [lrs_pkg::LABEL_W-1:0]  out_highest_label
);

  localparam int SW = lrs_pkg::SUM_W;
  localparam int CW = lrs_pkg::CENT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    st_r;
  logic [3:0]    step_r;
  logic [SW-1:0] rem_x_r, rem_y_r;
  logic [CW-1:0] qx_r, qy_r;
  logic          satx_r, saty_r, zero_r;
  lrs_pkg::div_req_t hold_r;
  logic [SW:0]   trial;

  assign busy      = st_r != ST_IDLE;
  assign out_valid = st_r == ST_DONE;
  assign trial     = (SW+1)'(hold_r.area) << step_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: if (start) st_r <= ST_RUN;
        ST_RUN:  if (step_r == 4'd0) st_r <= ST_DONE;
        ST_DONE: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Restoring division of both sums by the area; a quotient that would pass
  // the centroid range is flagged up front.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      hold_r  <= req;
      rem_x_r <= req.sum_x;
      rem_y_r <= req.sum_y;
      qx_r    <= '0;
      qy_r    <= '0;
      step_r  <= 4'(CW - 1);
      zero_r  <= req.area == '0;
      satx_r  <= {1'b0, req.sum_x[SW-1:CW]} >= req.area;
      saty_r  <= {1'b0, req.sum_y[SW-1:CW]} >= req.area;
    end else if (st_r == ST_RUN) begin
      if ({1'b0, rem_x_r} >= trial) begin
        rem_x_r      <= rem_x_r - trial[SW-1:0];
        qx_r[step_r] <= 1'b1;
      end
      if ({1'b0, rem_y_r} >= trial) begin
        rem_y_r      <= rem_y_r - trial[SW-1:0];
        qy_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 4'd1;
    end
  end

  assign out_region_area   = hold_r.area;
  assign out_centroid_x    = zero_r ? '0 : (satx_r ? lrs_pkg::CENT_CAP : qx_r);
  assign out_centroid_y    = zero_r ? '0 : (saty_r ? lrs_pkg::CENT_CAP : qy_r);
  assign out_perimeter     = hold_r.perimeter;
  assign out_in_range      = hold_r.in_range;
  assign out_highest_label = hold_r.highest_label;

endmodule

@@ rtl/label_region_statistics_core.sv @@
// Top level of the label region statistics block.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_cmd, in_label
//   out      output     out_valid/out_stall  area, centroids, perimeter, in_range, label
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// The front takes no new transaction while the last one sits in its classification stage (row buffer read, then write).
// The back issues one table operation per table entry a pixel touches: one to three operations.
// A read runs ten quotient steps in the centroid divider, which holds the result.
// After reset a clearing pass over all MAX_LABELS entries zeroes the tables; in_stall is high.
// A stalled result holds the divider; pixels keep flowing until the queue is almost full.
`timescale 1ns / 1ps

module label_region_statistics_core #(
  parameter int MAX_LABELS = 1024,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [lrs_pkg::LABEL_W-1:0]    in_label,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lrs_pkg::AREA_W-1:0]     out_region_area,
  output logic [lrs_pkg::CENT_W-1:0]     out_centroid_x,
  output logic [lrs_pkg::CENT_W-1:0]     out_centroid_y,
  output logic [lrs_pkg::PERIM_W-1:0]    out_perimeter,
  output logic                           out_in_range,
  output logic [lrs_pkg::LABEL_W-1:0]    out_highest_label,
  input  logic                           cfg_wr_en,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrs_pkg::CFG_W-1:0]      cfg_data
);

  localparam int IW = $clog2(MAX_LABELS);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QW = 1 + IW + 2 + 1 + IW + 1 + IW + XW + YW + lrs_pkg::LABEL_W;

  lrs_pkg::cfg_t     cfg_r;
  lrs_pkg::div_req_t div_req;
  logic              push, pop, head_valid, almost_full, clearing, div_busy, div_start;
  logic [QW-1:0]     push_data, head_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= lrs_pkg::DIM_RESET;
      cfg_r.image_height <= lrs_pkg::DIM_RESET;
      cfg_r.area_min     <= lrs_pkg::AREA_MIN_RESET;
      cfg_r.area_max     <= lrs_pkg::AREA_MAX_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lrs_pkg::CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[lrs_pkg::DIM_W-1:0];
        lrs_pkg::CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[lrs_pkg::DIM_W-1:0];
        lrs_pkg::CFG_AREA_MIN:     cfg_r.area_min     <= cfg_data;
        lrs_pkg::CFG_AREA_MAX:     cfg_r.area_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  lrs_front #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .hold      (clearing || almost_full),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_label  (in_label),
    .push      (push),
    .push_data (push_data)
  );

  lrs_queue #(
    .WIDTH (QW),
    .DEPTH (lrs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_data   (push_data),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .almost_full (almost_full)
  );

  lrs_back #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .div_busy   (div_busy),
    .div_start  (div_start),
    .div_req    (div_req),
    .clearing   (clearing)
  );

  lrs_div u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (div_start),
    .req               (div_req),
    .busy              (div_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_region_area   (out_region_area),
    .out_centroid_x    (out_centroid_x),
    .out_centroid_y    (out_centroid_y),
    .out_perimeter     (out_perimeter),
    .out_in_range      (out_in_range),
    .out_highest_label (out_highest_label)
  );

endmodule

@@ rtl/lrs_checker.sv @@
// Port-level checker of the label region statistics block and its bind.
`timescale 1ns / 1ps
`include "label_region_statistics_core_assert.svh"

module lrs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_cmd,
  input logic [lrs_pkg::LABEL_W-1:0]    in_label,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lrs_pkg::AREA_W-1:0]     out_region_area,
  input logic [lrs_pkg::CENT_W-1:0]     out_centroid_x,
  input logic [lrs_pkg::CENT_W-1:0]     out_centroid_y,
  input logic [lrs_pkg::PERIM_W-1:0]    out_perimeter,
  input logic                           out_in_range,
  input logic [lrs_pkg::LABEL_W-1:0]    out_highest_label,
  input logic                           cfg_wr_en,
  input logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lrs_pkg::CFG_W-1:0]      cfg_data
);

  // A stalled result transaction stays up with the same area.
  `LRS_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_region_area))

  // An empty region reports both centroids as zero.
  `LRS_ASSERT_RST(a_empty_centroid, out_valid && out_region_area == '0 |-> out_centroid_x == '0 && out_centroid_y == '0)

  // The tables are being cleared right after reset, so no input is taken.
  `LRS_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> in_stall)

endmodule

bind label_region_statistics_core lrs_checker u_lrs_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for the label region statistics core.
`timescale 1ns / 1ps

module tb;
  import lrs_pkg::*;

  localparam int NUM_LABELS = 1024;
  localparam int COLS_MAX   = 1024;
  localparam int ROWS_MAX   = 1024;
  localparam int SETTLE_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 3000000;

  // Idling modes of the two channels.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Input command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct {
    logic [AREA_W-1:0]  area;
    logic [CENT_W-1:0]  cx;
    logic [CENT_W-1:0]  cy;
    logic [PERIM_W-1:0] perim;
    logic               in_rng;
    logic [LABEL_W-1:0] top_label;
  } region_stats_t;

  // Region statistics tracker and comparison against the block's results.
  class region_scoreboard;
    logic [AREA_W-1:0]  area_q [NUM_LABELS];
    logic [SUM_W-1:0]   sx_q [NUM_LABELS];
    logic [SUM_W-1:0]   sy_q [NUM_LABELS];
    logic [PERIM_W-1:0] perim_q [NUM_LABELS];
    logic [LABEL_W-1:0] prev_row [COLS_MAX];
    logic [LABEL_W-1:0] left_lab;
    int unsigned col, row;
    logic [LABEL_W-1:0] top_lab;
    logic [DIM_W-1:0]   width_r, height_r;
    logic [AREA_W-1:0]  amin_r, amax_r;
    region_stats_t pending_stats[$];
    int errors;

    function new();
      for (int i = 0; i < NUM_LABELS; i++) begin
        area_q[i] = '0; sx_q[i] = '0; sy_q[i] = '0; perim_q[i] = '0;
      end
      foreach (prev_row[i]) prev_row[i] = '0;
      left_lab = '0; col = 0; row = 0; top_lab = '0;
      width_r = DIM_RESET; height_r = DIM_RESET;
      amin_r = AREA_MIN_RESET; amax_r = AREA_MAX_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_r = data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r = data[DIM_W-1:0];
        CFG_AREA_MIN:     amin_r = data[AREA_W-1:0];
        default:          amax_r = data[AREA_W-1:0];
      endcase
    endfunction

    function longint sat(longint a, longint b, longint cap);
      return (a + b > cap) ? cap : a + b;
    endfunction

    function logic [CENT_W-1:0] mean(longint sum, longint cnt);
      longint q;
      if (cnt == 0) return '0;
      q = sum / cnt;
      return (q > CENT_CAP) ? CENT_CAP : CENT_W'(q);
    endfunction

    function void bump(logic [LABEL_W-1:0] lab);
      perim_q[lab] = PERIM_W'(sat(perim_q[lab], 1, PERIM_CAP));
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    // Applies one accepted input transaction to the tracked tables.
    function void note_input(logic cmd, logic [LABEL_W-1:0] lab);
      region_stats_t s;
      int unsigned w, h, x, y;
      bit last_col, last_row;
      if (cmd == CMD_READ) begin
        s.area = area_q[lab];
        s.cx = mean(sx_q[lab], area_q[lab]);
        s.cy = mean(sy_q[lab], area_q[lab]);
        s.perim = perim_q[lab];
        s.in_rng = (amin_r <= area_q[lab]) && (area_q[lab] <= amax_r);
        s.top_label = top_lab;
        pending_stats.push_back(s);
        area_q[lab] = '0; sx_q[lab] = '0; sy_q[lab] = '0; perim_q[lab] = '0;
        return;
      end
      w = eff_dim(width_r, COLS_MAX);
      h = eff_dim(height_r, ROWS_MAX);
      x = col; y = row;
      last_col = x >= w - 1;
      last_row = y >= h - 1;
      if (x >= COLS_MAX) x = COLS_MAX - 1;
      area_q[lab] = AREA_W'(sat(area_q[lab], 1, AREA_CAP));
      sx_q[lab] = SUM_W'(sat(sx_q[lab], x, SUM_CAP));
      sy_q[lab] = SUM_W'(sat(sy_q[lab], y, SUM_CAP));
      if (x == 0 || y == 0 || last_col || last_row) bump(lab);
      if (y != 0 && prev_row[x] != lab) begin
        bump(lab);
        bump(prev_row[x]);
      end
      if (x != 0 && left_lab != lab) begin
        bump(lab);
        bump(left_lab);
      end
      prev_row[x] = lab;
      left_lab = lab;
      if (lab > top_lab) top_lab = lab;
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
    endfunction

    // Compares one accepted result with the oldest expected statistics.
    function void check_result(region_stats_t got);
      region_stats_t e;
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result transaction, area %0d", $time, got.area);
        errors++;
        return;
      end
      e = pending_stats.pop_front();
      if (got.area !== e.area) begin
        $display("%0t: area expected %0d actual %0d", $time, e.area, got.area);
        errors++;
      end
      if (got.cx !== e.cx) begin
        $display("%0t: centroid_x expected %0d actual %0d", $time, e.cx, got.cx);
        errors++;
      end
      if (got.cy !== e.cy) begin
        $display("%0t: centroid_y expected %0d actual %0d", $time, e.cy, got.cy);
        errors++;
      end
      if (got.perim !== e.perim) begin
        $display("%0t: perimeter expected %0d actual %0d", $time, e.perim, got.perim);
        errors++;
      end
      if (got.in_rng !== e.in_rng) begin
        $display("%0t: in_range expected %0d actual %0d", $time, e.in_rng, got.in_rng);
        errors++;
      end
      if (got.top_label !== e.top_label) begin
        $display("%0t: highest_label expected %0d actual %0d", $time, e.top_label,
                 got.top_label);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [LABEL_W-1:0] in_label = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AREA_W-1:0] out_region_area;
  logic [CENT_W-1:0] out_centroid_x, out_centroid_y;
  logic [PERIM_W-1:0] out_perimeter;
  logic out_in_range;
  logic [LABEL_W-1:0] out_highest_label;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  region_scoreboard sb = new();
  idle_mode_t idle_mode = IDLE_NONE;
  longint cycles = 0;

  label_region_statistics_core DUT (.*);

  always #6 clk = ~clk;

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("label_region_statistics_core test failed");
      $finish;
    end
  end

  // Receiver stall pattern follows the current idling mode.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= $urandom_range(99) < 55;
      IDLE_BOTH:     out_stall <= $urandom_range(99) < 29;
      default:       out_stall <= 1'b0;
    endcase
  end

  // Result monitor.
  always @(posedge clk) begin
    region_stats_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.area = out_region_area;
      got.cx = out_centroid_x;
      got.cy = out_centroid_y;
      got.perim = out_perimeter;
      got.in_rng = out_in_range;
      got.top_label = out_highest_label;
      sb.check_result(got);
    end
  end

  // Sends one transaction, with a random gap before it in the sender idling modes.
  task automatic send(logic cmd, logic [LABEL_W-1:0] lab);
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 55 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    @(negedge clk);
    while ($urandom_range(99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_label = lab;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, lab);
  endtask

  // Writes all four registers once the block has drained.
  task automatic configure(int w, int h, int amin, int amax);
    int vals[4];
    vals = '{w, h, amin, amax};
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = CFG_W'(vals[i]);
      sb.set_reg(CFG_IDX_W'(i), CFG_W'(vals[i]));
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
  endtask

  // Mostly a small palette of labels so regions touch, sometimes any label.
  function automatic logic [LABEL_W-1:0] pick_label(int base);
    if ($urandom_range(9) < 7) return LABEL_W'(base + $urandom_range(5));
    return LABEL_W'($urandom);
  endfunction

  // Random phase: pixels in raster order with reads mixed in, then reads of the palette.
  task automatic run_phase(int w, int h, int amin, int amax, int pixels, idle_mode_t m);
    int base;
    configure(w, h, amin, amax);
    idle_mode = m;
    base = $urandom_range(1017);
    for (int p = 0; p < pixels; p++) begin
      if ($urandom_range(5) == 0) send(CMD_READ, pick_label(base));
      send(CMD_PIXEL, pick_label(base));
    end
    for (int i = 0; i <= 5; i++) send(CMD_READ, LABEL_W'(base + i));
  endtask

  initial begin
    logic [LABEL_W-1:0] pattern[12];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a 4x3 image with the extreme labels, then reads including empty
    // entries and a second read of a cleared entry.
    configure(4, 3, 0, 1048576);
    pattern = '{0, 0, 1023, 5, 0, 1023, 1023, 5, 7, 7, 7, 5};
    foreach (pattern[i]) send(CMD_PIXEL, pattern[i]);
    send(CMD_READ, 0);
    send(CMD_READ, 1023);
    send(CMD_READ, 5);
    send(CMD_READ, 7);
    send(CMD_READ, 500);
    send(CMD_READ, 0);

    // Zero dimensions act as one pixel; empty range bounds inverted.
    run_phase(0, 0, 1048576, 0, 40, IDLE_SENDER);
    // Oversized width acts as the widest row; the phase ends partway along the row,
    // so the next image starts at a column past its own width.
    run_phase(2047, 1, 1, 5, 240, IDLE_NONE);
    run_phase(5, 4, 2, 6, 100, IDLE_SENDER);
    run_phase(16, 8, 0, 10, 128, IDLE_RECEIVER);
    run_phase(3, 9, 3, 1048576, 54, IDLE_BOTH);
    run_phase(7, 2, 1, 2097151, 56, IDLE_NONE);
    // Oversized height acts as the tallest image; the run ends inside it.
    run_phase(1, 2047, 4, 1048576, 30, IDLE_BOTH);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("label_region_statistics_core test passed");
    end else begin
      $display("label_region_statistics_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lrs_pkg.sv
rtl/lrs_ram.sv
rtl/lrs_front.sv
rtl/lrs_queue.sv
rtl/lrs_back.sv
rtl/lrs_div.sv
rtl/label_region_statistics_core.sv
rtl/lrs_checker.sv
bench/tb.sv
